// File: rtl/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
package bale_pkg;

  // Default list capacity
  localparam int unsigned DefDepth = 64;

  // Field widths
  localparam int unsigned ReqW     = 4;
  localparam int unsigned PosW     = 7;
  localparam int unsigned ValW     = 32;
  localparam int unsigned StatW    = 2;
  localparam int unsigned CntOutW  = 7;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 48;

  // Request codes
  typedef enum logic [ReqW-1:0] {
    ReqPushBack  = 4'd0,
    ReqPopBack   = 4'd1,
    ReqPushFront = 4'd2,
    ReqPopFront  = 4'd3,
    ReqInsert    = 4'd4,
    ReqErase     = 4'd5,
    ReqModify    = 4'd6,
    ReqFind      = 4'd7,
    ReqRemove    = 4'd8,
    ReqSort      = 4'd9,
    ReqBsearch   = 4'd10,
    ReqDump      = 4'd11
  } req_e;

  // Status codes
  localparam logic [StatW-1:0] StOk    = 2'd0;
  localparam logic [StatW-1:0] StFull  = 2'd1;
  localparam logic [StatW-1:0] StEmpty = 2'd2;
  localparam logic [StatW-1:0] StRange = 2'd3;

endpackage

// File: rtl/bale_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bale_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write on enable, read every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bounded_array_list_engine_core.sv
// Top level: bounded array list engine with RAM storage and sequencing control.
// Shifting ops move each displaced element by a RAM read and write; modify is a single
//   write; find/remove scan the whole list; dump returns one element per transaction,
//   waiting on output back-pressure; bsearch reads and then compares on each probe.
// Sort repeats a pass over the list until a pass makes no swap (up to count passes).
// One request at a time; the element RAM read port (one access per cycle) sets the pace.
// Reset clears the element count and control; RAM contents stay undefined until written.
module bounded_array_list_engine_core #(
  parameter int unsigned DEPTH = bale_pkg::DefDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // position[6:0], value[38:7], zero pad
  input  logic [bale_pkg::InDataW-1:0]   s_axis_tdata_i,
  // req_type[3:0]
  input  logic [bale_pkg::ReqW-1:0]      s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status[1:0], found[2], count[9:3], elem_value[41:10], zero pad
  output logic [bale_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // elem_valid[0]
  output logic [0:0]                     m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);
  import bale_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned BW = CW + 1;
  localparam int unsigned XW = (CW > PosW) ? CW : PosW;

  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SScan  = 6'b000010,
    SFin   = 6'b000100,
    SBsRd  = 6'b001000,
    SBsCmp = 6'b010000,
    SResp  = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [ValW-1:0]   val_q, val_d;
  logic [AW-1:0]     at_q, at_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [StatW-1:0]  status_q, status_d;
  logic              found_q, found_d;
  logic [CW-1:0]     n_q, n_d;
  logic [AW-1:0]     rd_q, rd_d;
  logic              rv_q, rv_d;
  logic [AW-1:0]     ri_q, ri_d;
  logic [CW-1:0]     j_q, j_d;
  logic [ValW-1:0]   carry_q, carry_d;
  logic              swap_q, swap_d;
  logic signed [BW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [AW-1:0]     mid_q, mid_d;

  logic              ov_q, ov_d;
  logic [StatW-1:0]  o_status_q, o_status_d;
  logic              o_found_q, o_found_d;
  logic [CntOutW-1:0] o_cnt_q, o_cnt_d;
  logic [ValW-1:0]   o_elem_q, o_elem_d;
  logic              o_evalid_q, o_evalid_d;
  logic              o_last_q, o_last_d;

  logic              we;
  logic [AW-1:0]     waddr, raddr;
  logic [ValW-1:0]   wdata, rdata;

  logic              out_free, issue_ok, shift_up, full, empty;
  logic [XW-1:0]     pos_x, cnt_x, at_x;
  logic [BW:0]       bs_sum;
  logic [AW-1:0]     bs_mid;
  req_e              req_in;

  bale_ram #(.Width(ValW), .Depth(DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_free = !ov_q || m_axis_tready_i;
  assign req_in   = req_e'(s_axis_tuser_i);
  assign pos_x    = XW'(s_axis_tdata_i[PosW-1:0]);
  assign cnt_x    = XW'(cnt_q);
  assign full     = (cnt_q == CW'(DEPTH));
  assign empty    = (cnt_q == '0);
  assign shift_up = (req_q == ReqPushBack) || (req_q == ReqPushFront) || (req_q == ReqInsert);
  assign issue_ok = (n_q != '0) && ((req_q != ReqDump) || (!rv_q && out_free));
  assign bs_sum   = (BW+1)'($unsigned(lo_q)) + (BW+1)'($unsigned(hi_q));
  assign bs_mid   = AW'(bs_sum[BW:1]);
  assign s_axis_tready_o = (state_q == SIdle);

  // Sequence requests over the element RAM
  always_comb begin
    state_d = state_q;  req_d = req_q;  val_d = val_q;  at_d = at_q;  cnt_d = cnt_q;
    status_d = status_q;  found_d = found_q;  n_d = n_q;  rd_d = rd_q;  rv_d = 1'b0;
    ri_d = ri_q;  j_d = j_q;  carry_d = carry_q;  swap_d = swap_q;
    lo_d = lo_q;  hi_d = hi_q;  mid_d = mid_q;
    ov_d = ov_q && !m_axis_tready_i;
    o_status_d = o_status_q;  o_found_d = o_found_q;  o_cnt_d = o_cnt_q;
    o_elem_d = o_elem_q;  o_evalid_d = o_evalid_q;  o_last_d = o_last_q;
    we = 1'b0;  waddr = '0;  wdata = val_q;  raddr = rd_q;
    at_x = '0;

    case (state_q)
      SIdle: begin
        if (s_axis_tvalid_i) begin
          req_d    = req_in;
          val_d    = s_axis_tdata_i[PosW +: ValW];
          status_d = StOk;
          found_d  = 1'b0;
          state_d  = SResp;
          case (req_in)
            ReqPushBack, ReqPushFront, ReqInsert: begin
              at_x = (req_in == ReqPushBack) ? cnt_x :
                     (req_in == ReqPushFront) ? '0 : pos_x;
              if (full) begin
                status_d = StFull;
              end else if (at_x > cnt_x) begin
                status_d = StRange;
              end else begin
                at_d    = AW'(at_x);
                rd_d    = AW'(cnt_q - CW'(1));
                n_d     = CW'(cnt_x - at_x);
                state_d = SScan;
              end
            end
            ReqPopBack, ReqPopFront, ReqErase: begin
              at_x = (req_in == ReqPopBack) ? (cnt_x - XW'(1)) :
                     (req_in == ReqPopFront) ? '0 : pos_x;
              if (empty) begin
                status_d = StEmpty;
              end else if (at_x >= cnt_x) begin
                status_d = StRange;
              end else begin
                rd_d    = AW'(at_x + XW'(1));
                n_d     = CW'(cnt_x - XW'(1) - at_x);
                state_d = SScan;
              end
            end
            ReqModify: begin
              if (pos_x >= cnt_x) begin
                status_d = StRange;
              end else begin
                we    = 1'b1;
                waddr = AW'(pos_x);
                wdata = s_axis_tdata_i[PosW +: ValW];
              end
            end
            ReqFind, ReqRemove, ReqDump: begin
              rd_d    = '0;
              n_d     = cnt_q;
              j_d     = '0;
              state_d = SScan;
            end
            ReqSort: begin
              if (cnt_q > CW'(1)) begin
                rd_d    = '0;
                n_d     = cnt_q;
                swap_d  = 1'b0;
                state_d = SScan;
              end
            end
            ReqBsearch: begin
              lo_d    = '0;
              hi_d    = $signed(BW'(cnt_q) - BW'(1));
              state_d = SBsRd;
            end
            default: begin
              state_d = SResp;
            end
          endcase
        end
      end

      SScan: begin
        // Issue the next read
        if (issue_ok) begin
          n_d  = n_q - CW'(1);
          rd_d = shift_up ? (rd_q - AW'(1)) : (rd_q + AW'(1));
          rv_d = 1'b1;
          ri_d = rd_q;
        end
        // Act on returned data
        if (rv_q) begin
          case (req_q)
            ReqPushBack, ReqPushFront, ReqInsert: begin
              we = 1'b1;  waddr = ri_q + AW'(1);  wdata = rdata;
            end
            ReqPopBack, ReqPopFront, ReqErase: begin
              we = 1'b1;  waddr = ri_q - AW'(1);  wdata = rdata;
            end
            ReqFind: begin
              if (rdata == val_q) found_d = 1'b1;
            end
            ReqRemove: begin
              if (rdata != val_q) begin
                we = 1'b1;  waddr = AW'(j_q);  wdata = rdata;
                j_d = j_q + CW'(1);
              end
            end
            ReqSort: begin
              if (ri_q == '0) begin
                carry_d = rdata;
              end else if ($signed(rdata) < $signed(carry_q)) begin
                we = 1'b1;  waddr = ri_q - AW'(1);  wdata = rdata;
                swap_d = 1'b1;
              end else begin
                we = 1'b1;  waddr = ri_q - AW'(1);  wdata = carry_q;
                carry_d = rdata;
              end
            end
            ReqDump: begin
              ov_d       = 1'b1;
              o_status_d = StOk;
              o_found_d  = 1'b0;
              o_cnt_d    = CntOutW'(cnt_q);
              o_elem_d   = rdata;
              o_evalid_d = 1'b1;
              o_last_d   = ((CW'(ri_q) + CW'(1)) == cnt_q);
            end
            default: begin
              we = 1'b0;
            end
          endcase
        end
        if (n_q == '0 && !rv_q) state_d = SFin;
      end

      SFin: begin
        state_d = SResp;
        case (req_q)
          ReqPushBack, ReqPushFront, ReqInsert: begin
            we = 1'b1;  waddr = at_q;  wdata = val_q;
            cnt_d = cnt_q + CW'(1);
          end
          ReqPopBack, ReqPopFront, ReqErase: begin
            cnt_d = cnt_q - CW'(1);
          end
          ReqRemove: begin
            cnt_d = j_q;
          end
          ReqSort: begin
            we = 1'b1;  waddr = AW'(cnt_q - CW'(1));  wdata = carry_q;
            if (swap_q) begin
              rd_d    = '0;
              n_d     = cnt_q;
              swap_d  = 1'b0;
              state_d = SScan;
            end
          end
          ReqDump: begin
            if (!empty) state_d = SIdle;
          end
          default: begin
            state_d = SResp;
          end
        endcase
      end

      SBsRd: begin
        if (lo_q > hi_q) begin
          state_d = SResp;
        end else begin
          raddr   = bs_mid;
          mid_d   = bs_mid;
          state_d = SBsCmp;
        end
      end

      SBsCmp: begin
        state_d = SBsRd;
        if ($signed(val_q) > $signed(rdata)) begin
          lo_d = $signed(BW'(mid_q) + BW'(1));
        end else if ($signed(val_q) < $signed(rdata)) begin
          hi_d = $signed(BW'(mid_q) - BW'(1));
        end else begin
          found_d = 1'b1;
          state_d = SResp;
        end
      end

      SResp: begin
        if (out_free) begin
          ov_d       = 1'b1;
          o_status_d = status_q;
          o_found_d  = found_q;
          o_cnt_d    = CntOutW'(cnt_q);
          o_elem_d   = '0;
          o_evalid_d = 1'b0;
          o_last_d   = 1'b1;
          state_d    = SIdle;
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      req_q   <= ReqPushBack;
      cnt_q   <= '0;
      n_q     <= '0;
      rv_q    <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      req_q   <= req_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      rv_q    <= rv_d;
      ov_q    <= ov_d;
    end
  end

  // Working and output payload
  always_ff @(posedge clk_i) begin
    val_q      <= val_d;
    at_q       <= at_d;
    status_q   <= status_d;
    found_q    <= found_d;
    rd_q       <= rd_d;
    ri_q       <= ri_d;
    j_q        <= j_d;
    carry_q    <= carry_d;
    swap_q     <= swap_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    o_status_q <= o_status_d;
    o_found_q  <= o_found_d;
    o_cnt_q    <= o_cnt_d;
    o_elem_q   <= o_elem_d;
    o_evalid_q <= o_evalid_d;
    o_last_q   <= o_last_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = {6'b0, o_elem_q, o_cnt_q, o_found_q, o_status_q};
  assign m_axis_tuser_o  = o_evalid_q;
  assign m_axis_tlast_o  = o_last_q;

  // Count stays within capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("element count exceeds capacity");

  // No read left in flight once idle
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SIdle |-> !rv_q)
    else $error("read in flight while idle");

  // Dump data only lands in an empty output register
  a_dump_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan && rv_q && req_q == ReqDump) |-> !ov_q)
    else $error("dump element would overwrite pending transaction");

endmodule

// File: tb/tb.sv
// Testbench for the bounded array list engine: directed and random requests checked against a list model.
`timescale 1ns / 1ps

module tb;
  import bale_pkg::*;

  localparam int unsigned Depth = 64;

  // Expected result of one output transaction
  typedef struct packed {
    logic [StatW-1:0]   status;
    logic               found;
    logic [CntOutW-1:0] count;
    logic [ValW-1:0]    elem;
    logic               elem_valid;
    logic               last;
  } list_res_t;

  // List model and store of expected results
  class list_scoreboard;
    logic signed [ValW-1:0] elems[Depth];
    int unsigned            n_elems;
    list_res_t              pending[$];
    int unsigned            n_bad;

    function void clear();
      n_elems = 0;
      n_bad = 0;
      pending.delete();
    endfunction

    function void push_res(logic [StatW-1:0] st, logic fnd);
      list_res_t r;
      r = '{st, fnd, n_elems[CntOutW-1:0], '0, 1'b0, 1'b1};
      pending.push_back(r);
    endfunction

    // Apply one accepted request and queue its results
    function void note_request(logic [ReqW-1:0] req, logic [PosW-1:0] pos,
                               logic signed [ValW-1:0] x);
      int unsigned at, j, lo_i;
      int lo, hi, mid;
      logic fnd;
      logic [StatW-1:0] st;
      logic signed [ValW-1:0] t;
      list_res_t r;
      st = StOk;
      fnd = 1'b0;
      case (req)
        ReqPushBack, ReqPushFront, ReqInsert: begin
          at = (req == ReqPushBack) ? n_elems : (req == ReqPushFront) ? 0 : pos;
          if (n_elems >= Depth) st = StFull;
          else if (at > n_elems) st = StRange;
          else begin
            for (j = n_elems; j > at; j--) elems[j] = elems[j-1];
            elems[at] = x;
            n_elems++;
          end
        end
        ReqPopBack, ReqPopFront, ReqErase: begin
          if (n_elems == 0) st = StEmpty;
          else begin
            at = (req == ReqPopBack) ? n_elems - 1 : (req == ReqPopFront) ? 0 : pos;
            if (at >= n_elems) st = StRange;
            else begin
              for (j = at; j + 1 < n_elems; j++) elems[j] = elems[j+1];
              n_elems--;
            end
          end
        end
        ReqModify: begin
          if (pos >= n_elems) st = StRange;
          else elems[pos] = x;
        end
        ReqFind: begin
          for (j = 0; j < n_elems; j++) if (elems[j] == x) fnd = 1'b1;
        end
        ReqRemove: begin
          lo_i = 0;
          for (j = 0; j < n_elems; j++) if (elems[j] != x) elems[lo_i++] = elems[j];
          n_elems = lo_i;
        end
        ReqSort: begin
          for (at = 0; at < n_elems; at++)
            for (j = n_elems - 1; j > at; j--)
              if (elems[j] < elems[j-1]) begin
                t = elems[j];
                elems[j] = elems[j-1];
                elems[j-1] = t;
              end
        end
        ReqBsearch: begin
          lo = 0;
          hi = int'(n_elems) - 1;
          while (lo <= hi && !fnd) begin
            mid = lo + (hi - lo) / 2;
            if (x > elems[mid]) lo = mid + 1;
            else if (x < elems[mid]) hi = mid - 1;
            else fnd = 1'b1;
          end
        end
        ReqDump: begin
          if (n_elems != 0) begin
            for (j = 0; j < n_elems; j++) begin
              r = '{StOk, 1'b0, n_elems[CntOutW-1:0], elems[j], 1'b1, j + 1 == n_elems};
              pending.push_back(r);
            end
            return;
          end
        end
        default: ;
      endcase
      push_res(st, fnd);
    endfunction

    // Compare one output transaction with the oldest expectation
    function void check_result(list_res_t got);
      list_res_t exp;
      if (pending.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h", got);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        n_bad++;
        if (n_bad <= 10)
          $display({"mismatch: exp st=%0d f=%0d n=%0d v=%h ev=%0d l=%0d,",
                    " got st=%0d f=%0d n=%0d v=%h ev=%0d l=%0d"},
                   exp.status, exp.found, exp.count, exp.elem, exp.elem_valid, exp.last,
                   got.status, got.found, got.count, got.elem, got.elem_valid, got.last);
      end
    endfunction
  endclass

  logic                clk_i, rst_ni;
  logic                s_axis_tvalid_i, s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic [ReqW-1:0]     s_axis_tuser_i;
  logic                m_axis_tvalid_o, m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [0:0]          m_axis_tuser_o;
  logic                m_axis_tlast_o;

  list_scoreboard sb;
  bit             hold_req;
  bit             stim_done;

  bounded_array_list_engine_core dut (.*);

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned rand_gap();
    if ($urandom_range(0, 9) < 4) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [ValW-1:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7) - 4;
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $urandom();
    endcase
  endfunction

  // Send one request and wait until it is accepted; valid stays up for the next one
  task automatic send_req(logic [ReqW-1:0] req, logic [PosW-1:0] pos, logic [ValW-1:0] x,
                          bit no_gap = 0);
    int unsigned g;
    g = no_gap ? 0 : rand_gap();
    if (g != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {1'b0, x, pos};
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(req, pos, x);
  endtask

  // Pick a request, mostly legal, biased by fill level
  task automatic send_random();
    logic [ReqW-1:0] req;
    logic [PosW-1:0] pos;
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 30) req = $urandom_range(0, 4) == 0 ? ReqPushFront : ReqPushBack;
    else if (k < 40) req = ReqInsert;
    else if (k < 95) req = ReqW'($urandom_range(0, 15));
    else req = $urandom_range(1, 5) == 1 ? ReqPopFront : ReqPopBack;
    if ($urandom_range(0, 9) == 0) pos = PosW'($urandom_range(0, 127));
    else pos = PosW'($urandom_range(0, sb.n_elems));
    if (req == ReqSort && sb.n_elems > 24 && $urandom_range(0, 1)) req = ReqFind;
    send_req(req, pos, rand_val());
  endtask

  // Receiver: random stalls, plus one long hold-off counted here
  initial begin
    int unsigned g;
    bit held;
    held = 1'b0;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        g = rand_gap();
        if (g != 0) begin
          m_axis_tready_i <= 1'b0;
          repeat (g) @(posedge clk_i);
        end
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Monitor output transactions
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result('{m_axis_tdata_o[1:0], m_axis_tdata_o[2], m_axis_tdata_o[9:3],
                        m_axis_tdata_o[41:10], m_axis_tuser_o[0], m_axis_tlast_o});
  end

  // Stimulus
  initial begin
    int unsigned i;
    sb = new();
    sb.clear();
    hold_req = 1'b0;
    stim_done = 1'b0;
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    s_axis_tuser_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty list cases, then small-list cases
    send_req(ReqPopBack, 0, 0);
    send_req(ReqPopFront, 0, 0);
    send_req(ReqErase, 0, 0);
    send_req(ReqFind, 0, 0);
    send_req(ReqBsearch, 0, 0);
    send_req(ReqDump, 0, 0);
    send_req(ReqModify, 0, 0);
    send_req(4'd15, 7'h7f, 32'hffff_ffff);
    send_req(ReqInsert, 1, 5);
    send_req(ReqPushBack, 0, 32'h7fff_ffff);
    send_req(ReqPushFront, 0, 32'h8000_0000);
    send_req(ReqInsert, 1, 0);
    send_req(ReqErase, 3, 0);
    send_req(ReqModify, 7'h7f, 1);
    send_req(ReqBsearch, 0, 0);
    send_req(ReqSort, 0, 0);
    send_req(ReqBsearch, 0, 32'h7fff_ffff);
    send_req(ReqRemove, 0, 0);
    send_req(ReqDump, 0, 0);

    // Fill to capacity while the receiver holds off, then hit full cases, dump and remove
    hold_req = 1'b1;
    while (sb.n_elems < Depth) send_req(ReqPushBack, 0, $urandom_range(0, 9) - 5, 1);
    send_req(ReqPushBack, 0, 1);
    send_req(ReqInsert, 0, 1);
    send_req(ReqPushFront, 0, 1);
    send_req(ReqDump, 0, 0);
    send_req(ReqRemove, 0, 32'hffff_fffd);

    // Random
    for (i = 0; i < 170; i++) send_random();
    s_axis_tvalid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    int unsigned w;
    wait (stim_done);
    w = 0;
    while (sb.pending.size() != 0 && w < 400000) begin
      @(posedge clk_i);
      w++;
    end
    repeat (200) @(posedge clk_i);
    if (sb.pending.size() == 0 && sb.n_bad == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
